### design/assert_macros.svh
// Assertion macros used by the allocator top level.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle assertion failed");

`endif

### design/gha_pkg.sv
// Types, codes and constants of the generational handle allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package gha_pkg;

	localparam int ID_W      = 8;
	localparam int VER_W     = 8;
	localparam int CHUNK_W   = 8;
	localparam int DEPTH     = 256;
	localparam int CNT_W     = 9;
	localparam int MAX_ID    = 255;
	localparam int RESET_CHUNK = 64;

	localparam logic [CHUNK_W-1:0] CHUNK_RESET = CHUNK_W'(RESET_CHUNK);
	localparam logic [ID_W-1:0]    FILL_LAST   = ID_W'(1 + RESET_CHUNK);
	localparam logic [ID_W-1:0]    MAX_ID_V    = ID_W'(MAX_ID);
	localparam logic [CNT_W-1:0]   DEPTH_V     = CNT_W'(DEPTH);

	localparam logic [1:0] OP_CREATE      = 2'd0;
	localparam logic [1:0] OP_DESTROY     = 2'd1;
	localparam logic [1:0] OP_DESTROY_ALL = 2'd2;

	localparam logic [1:0] ST_DONE    = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_NO_ID   = 2'd2;

	typedef struct packed {
		logic [1:0]       operation;
		logic [ID_W-1:0]  handle_id;
		logic [VER_W-1:0] handle_version;
	} req_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [ID_W-1:0]  granted_id;
		logic [VER_W-1:0] granted_version;
	} rsp_t;

	typedef enum logic [2:0] {
		S_FILL,
		S_IDLE,
		S_GROW,
		S_POP,
		S_POP_VER,
		S_POP_FIN,
		S_DES_CHK,
		S_RESULT
	} state_t;

	typedef struct packed {
		logic capture;
		logic grow_setup;
		logic grow_step;
		logic pop_rd;
		logic ver_rd_pop;
		logic ver_rd_des;
		logic pop_fin;
		logic des_eval;
		logic clear_all;
		logic res_done;
		logic res_noid;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic count_le1;
		logic count_zero;
		logic grow_more;
		logic out_free;
	} sts_t;

endpackage

### design/gha_ctrl.sv
// Controller state machine of the handle allocator.
// Depends on gha_pkg; drives the datapath through gha_pkg::ctl_t commands.
module gha_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  logic [1:0]           cmd_op,
	input  gha_pkg::sts_t        sts,
	output logic                 ready,
	output gha_pkg::ctl_t        ctl
);

	gha_pkg::state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gha_pkg::S_FILL;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		ready     = 1'b0;
		unique case (state_q)
			gha_pkg::S_FILL: begin
				if (sts.grow_more) begin
					ctl.grow_step = 1'b1;
				end else begin
					state_nxt = gha_pkg::S_IDLE;
				end
			end
			gha_pkg::S_IDLE: begin
				ready = 1'b1;
				if (cmd_valid) begin
					ctl.capture = 1'b1;
					unique case (cmd_op)
						gha_pkg::OP_CREATE: begin
							ctl.grow_setup = 1'b1;
							state_nxt = sts.count_le1 ? gha_pkg::S_GROW : gha_pkg::S_POP;
						end
						gha_pkg::OP_DESTROY: begin
							ctl.ver_rd_des = 1'b1;
							state_nxt = gha_pkg::S_DES_CHK;
						end
						gha_pkg::OP_DESTROY_ALL: begin
							ctl.clear_all = 1'b1;
							ctl.res_done  = 1'b1;
							state_nxt = gha_pkg::S_RESULT;
						end
						default: begin
							ctl.res_done = 1'b1;
							state_nxt = gha_pkg::S_RESULT;
						end
					endcase
				end
			end
			gha_pkg::S_GROW: begin
				if (sts.grow_more) begin
					ctl.grow_step = 1'b1;
				end else begin
					state_nxt = gha_pkg::S_POP;
				end
			end
			gha_pkg::S_POP: begin
				if (sts.count_zero) begin
					ctl.res_noid = 1'b1;
					state_nxt = gha_pkg::S_RESULT;
				end else begin
					ctl.pop_rd = 1'b1;
					state_nxt = gha_pkg::S_POP_VER;
				end
			end
			gha_pkg::S_POP_VER: begin
				ctl.ver_rd_pop = 1'b1;
				state_nxt = gha_pkg::S_POP_FIN;
			end
			gha_pkg::S_POP_FIN: begin
				ctl.pop_fin = 1'b1;
				state_nxt = gha_pkg::S_RESULT;
			end
			gha_pkg::S_DES_CHK: begin
				ctl.des_eval = 1'b1;
				state_nxt = gha_pkg::S_RESULT;
			end
			gha_pkg::S_RESULT: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_nxt = gha_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = gha_pkg::S_IDLE;
			end
		endcase
	end

endmodule

### design/gha_dpath.sv
// Datapath of the handle allocator: version and free-list memories, pointers,
// next-fresh mark, chunk register and output register. Depends on gha_pkg.
module gha_dpath (
	input  logic                       clk,
	input  logic                       arst_n,
	input  gha_pkg::ctl_t              ctl,
	input  gha_pkg::req_t              cmd,
	input  logic                       cfg_we,
	input  logic [gha_pkg::CHUNK_W-1:0] cfg_wdata,
	input  logic                       res_stall,
	output gha_pkg::sts_t              sts,
	output logic                       res_valid,
	output gha_pkg::rsp_t              res
);

	logic [gha_pkg::VER_W-1:0] ver_mem  [gha_pkg::DEPTH];
	logic [gha_pkg::ID_W-1:0]  fifo_mem [gha_pkg::DEPTH];

	logic [gha_pkg::CHUNK_W-1:0] chunk_q;
	logic [gha_pkg::ID_W-1:0]    head_q, tail_q, last_q;
	logic [gha_pkg::CNT_W-1:0]   count_q, fresh_q;
	gha_pkg::req_t               req_q;
	logic [gha_pkg::ID_W-1:0]    fifo_rd_q, gid_q;
	logic [gha_pkg::VER_W-1:0]   ver_rd_q;
	gha_pkg::rsp_t               res_q, out_q;
	logic                        out_valid_q;

	logic                        full, des_ok, push_des;
	logic                        ver_we, ver_re;
	logic [gha_pkg::ID_W-1:0]    ver_waddr, ver_raddr, fifo_wdata;
	logic [gha_pkg::VER_W-1:0]   ver_wdata;
	logic [gha_pkg::CNT_W:0]     grow_sum;

	assign full     = (count_q == gha_pkg::DEPTH_V);
	assign des_ok   = (req_q.handle_id != '0) && ({1'b0, req_q.handle_id} < fresh_q) &&
		!full && (req_q.handle_version == ver_rd_q);
	assign push_des = ctl.des_eval && des_ok;

	assign sts.count_le1  = (count_q <= gha_pkg::CNT_W'(1));
	assign sts.count_zero = (count_q == '0);
	assign sts.grow_more  = (fresh_q <= {1'b0, last_q}) && !full;
	assign sts.out_free   = !out_valid_q || !res_stall;

	assign grow_sum   = {1'b0, fresh_q} + {2'b00, chunk_q};
	assign ver_we     = ctl.grow_step || push_des;
	assign ver_waddr  = ctl.grow_step ? fresh_q[gha_pkg::ID_W-1:0] : req_q.handle_id;
	assign ver_wdata  = ctl.grow_step ? '0 : ver_rd_q + gha_pkg::VER_W'(1);
	assign ver_re     = ctl.ver_rd_des || ctl.ver_rd_pop;
	assign ver_raddr  = ctl.ver_rd_des ? cmd.handle_id : fifo_rd_q;
	assign fifo_wdata = ctl.grow_step ? fresh_q[gha_pkg::ID_W-1:0] : req_q.handle_id;

	always_ff @(posedge clk) begin
		if (ver_we) begin
			ver_mem[ver_waddr] <= ver_wdata;
		end
		if (ver_re) begin
			ver_rd_q <= ver_mem[ver_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.grow_step || push_des) begin
			fifo_mem[tail_q] <= fifo_wdata;
		end
		if (ctl.pop_rd) begin
			fifo_rd_q <= fifo_mem[head_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_q <= gha_pkg::CHUNK_RESET;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= gha_pkg::CNT_W'(1);
			last_q  <= gha_pkg::FILL_LAST;
		end else begin
			if (cfg_we) begin
				chunk_q <= cfg_wdata;
			end
			if (ctl.grow_setup) begin
				last_q <= (grow_sum > (gha_pkg::CNT_W + 1)'(gha_pkg::MAX_ID)) ?
					gha_pkg::MAX_ID_V : grow_sum[gha_pkg::ID_W-1:0];
			end
			if (ctl.clear_all) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
				fresh_q <= gha_pkg::CNT_W'(1);
			end else if (ctl.grow_step) begin
				tail_q  <= tail_q + gha_pkg::ID_W'(1);
				count_q <= count_q + gha_pkg::CNT_W'(1);
				fresh_q <= fresh_q + gha_pkg::CNT_W'(1);
			end else if (push_des) begin
				tail_q  <= tail_q + gha_pkg::ID_W'(1);
				count_q <= count_q + gha_pkg::CNT_W'(1);
			end else if (ctl.pop_rd) begin
				head_q  <= head_q + gha_pkg::ID_W'(1);
				count_q <= count_q - gha_pkg::CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			req_q <= cmd;
		end
		if (ctl.ver_rd_pop) begin
			gid_q <= fifo_rd_q;
		end
		priority if (ctl.pop_fin) begin
			res_q <= '{status: gha_pkg::ST_DONE, granted_id: gid_q, granted_version: ver_rd_q};
		end else if (ctl.des_eval) begin
			res_q <= '{status: (des_ok ? gha_pkg::ST_DONE : gha_pkg::ST_INVALID),
				granted_id: '0, granted_version: '0};
		end else if (ctl.res_noid) begin
			res_q <= '{status: gha_pkg::ST_NO_ID, granted_id: '0, granted_version: '0};
		end else if (ctl.res_done) begin
			res_q <= '{status: gha_pkg::ST_DONE, granted_id: '0, granted_version: '0};
		end
		if (ctl.out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!res_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign res_valid = out_valid_q;
	assign res       = out_q;

endmodule

### design/generational_handle_allocator.sv
// Top level of the generational handle allocator: controller plus datapath.
// Depends on gha_pkg, gha_ctrl, gha_dpath and assert_macros.svh.
//
//   channel   handshake              payload
//   request   cmd_valid / cmd_stall  cmd  (gha_pkg::req_t)
//   result    res_valid / res_stall  res  (gha_pkg::rsp_t)
//   config    cfg_we                 cfg_wdata (chunk size)
//
// A create steps through POP, POP_VER and POP_FIN to RESULT before the output register is
// loaded, with GROW first adding IDs when the free list holds at most one; a destroy steps
// through DES_CHK to RESULT, and any other request goes straight to RESULT.
// The two dependent memory reads of a create, free list then version, set its extra states.
// After reset the block fills the free list with IDs 1 to 65, one per cycle, under cmd_stall.
// A held result does not block the next request; only loading a new one waits for it.
`include "assert_macros.svh"

module generational_handle_allocator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cmd_valid,
	output logic                        cmd_stall,
	input  gha_pkg::req_t               cmd,
	output logic                        res_valid,
	input  logic                        res_stall,
	output gha_pkg::rsp_t               res,
	input  logic                        cfg_we,
	input  logic [gha_pkg::CHUNK_W-1:0] cfg_wdata
);

	gha_pkg::ctl_t ctl;
	gha_pkg::sts_t sts;
	logic          ready;

	gha_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_op    (cmd.operation),
		.sts       (sts),
		.ready     (ready),
		.ctl       (ctl)
	);

	gha_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (ctl),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.res_stall (res_stall),
		.sts       (sts),
		.res_valid (res_valid),
		.res       (res)
	);

	assign cmd_stall = !ready;

	`ASSERT_SAME(a_load_when_free, clk, arst_n, ctl.out_load, sts.out_free)
	`ASSERT_SAME(a_pop_not_empty, clk, arst_n, ctl.pop_rd, !sts.count_zero)
	`ASSERT_SAME(a_grow_in_room, clk, arst_n, ctl.grow_step, sts.grow_more)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, cmd_valid && !cmd_stall, cmd_stall)

endmodule
